[src/assert_macros.svh]
// Assertion helpers used by the RTL core module.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/pmpn_pkg.sv]
package pmpn_pkg;

  localparam int unsigned MAX_NEIGHBORS_DEF = 4;
  localparam int unsigned ID_SLOTS          = 4;
  localparam int unsigned CNT_W             = 3;
  localparam int unsigned ID_W              = 8;
  localparam int unsigned VAL_W             = 32;
  localparam int unsigned CTR_W             = 8;

  localparam logic [CTR_W-1:0] CNT_MAX   = 8'hFF;
  localparam logic [CTR_W-1:0] DIAM_RST  = 8'd5;
  localparam logic [CNT_W-1:0] COUNT_RST = 3'd1;

  typedef enum logic [2:0] {
    REG_IN_COUNT  = 3'd0,
    REG_OUT_COUNT = 3'd1,
    REG_IN_IDS    = 3'd2,
    REG_OUT_IDS   = 3'd3,
    REG_INIT_MIN  = 3'd4,
    REG_DIAMETER  = 3'd5
  } reg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_MSG   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_SCAN,
    ST_SEND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]        in_count;
    logic [CNT_W-1:0]        out_count;
    logic [VAL_W-1:0]        in_ids;
    logic [VAL_W-1:0]        out_ids;
    logic [CTR_W-1:0]        diameter;
    logic                    init_wr;
    logic signed [VAL_W-1:0] init_val;
  } cfg_t;

  typedef struct packed {
    logic                    send_valid;
    logic [ID_W-1:0]         dest_id;
    logic signed [VAL_W-1:0] min_value;
    logic                    last;
    logic                    done_res;
  } res_t;

  // Byte i of a word of four packed node ids.
  function automatic logic [ID_W-1:0] id_at(input logic [VAL_W-1:0] ids,
                                            input logic [1:0] i);
    logic [VAL_W-1:0] shifted;
    shifted = ids >> {i, 3'b000};
    return shifted[ID_W-1:0];
  endfunction

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

[src/phase_min_propagation_node.sv]
// A start transaction advances the phase and sends the minimum to each out-neighbour.
// A message transaction updates the minimum and scans the in-neighbour slots; once all
// counts reach the phase it advances the phase, sends to the out-neighbours or gives a done
// result if there are none and the diameter is reached. An input after finishing gives one
// done result. Inputs are taken only in idle, after the last is through; sends wait for room.
// Reset: asynchronous, active low; slot counts, phase, finished flag clear, minimum is zero.
module phase_min_propagation_node #(
  parameter int unsigned MAX_NEIGHBORS = pmpn_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // source_id [7:0], value [39:8]
  input  logic [0:0]  s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // dest_id [7:0], min_value [39:8]
  output logic [1:0]  m_axis_tuser,   // send_valid [0], done_res [1]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pmpn_pkg::cfg_t cfg;
  pmpn_pkg::res_t res_push, res_out;
  logic           push, can_push;

  pmpn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmpn_core #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser[0]),
    .src_i      (s_axis_tdata[7:0]),
    .val_i      (s_axis_tdata[39:8]),
    .can_push_i (can_push),
    .push_o     (push),
    .res_o      (res_push)
  );

  pmpn_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res_push),
    .can_push_o (can_push),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (res_out)
  );

  assign m_axis_tdata = {res_out.min_value, res_out.dest_id};
  assign m_axis_tuser = {res_out.done_res, res_out.send_valid};
  assign m_axis_tlast = res_out.last;

endmodule

[src/pmpn_cfg.sv]
module pmpn_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output pmpn_pkg::cfg_t   cfg_o
);

  logic [pmpn_pkg::CNT_W-1:0] in_count_q, out_count_q;
  logic [31:0]                in_ids_q, out_ids_q, init_min_q;
  logic [pmpn_pkg::CTR_W-1:0] diameter_q;
  logic                       wr_en;
  pmpn_pkg::reg_idx_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = pmpn_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= pmpn_pkg::COUNT_RST;
      out_count_q <= pmpn_pkg::COUNT_RST;
      in_ids_q    <= '0;
      out_ids_q   <= '0;
      init_min_q  <= '0;
      diameter_q  <= pmpn_pkg::DIAM_RST;
    end else if (wr_en) begin
      case (reg_sel)
        pmpn_pkg::REG_IN_COUNT:  in_count_q  <= pwdata[pmpn_pkg::CNT_W-1:0];
        pmpn_pkg::REG_OUT_COUNT: out_count_q <= pwdata[pmpn_pkg::CNT_W-1:0];
        pmpn_pkg::REG_IN_IDS:    in_ids_q    <= pwdata;
        pmpn_pkg::REG_OUT_IDS:   out_ids_q   <= pwdata;
        pmpn_pkg::REG_INIT_MIN:  init_min_q  <= pwdata;
        pmpn_pkg::REG_DIAMETER:  diameter_q  <= pwdata[pmpn_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pmpn_pkg::REG_IN_COUNT:  prdata = 32'(in_count_q);
      pmpn_pkg::REG_OUT_COUNT: prdata = 32'(out_count_q);
      pmpn_pkg::REG_IN_IDS:    prdata = in_ids_q;
      pmpn_pkg::REG_OUT_IDS:   prdata = out_ids_q;
      pmpn_pkg::REG_INIT_MIN:  prdata = init_min_q;
      pmpn_pkg::REG_DIAMETER:  prdata = 32'(diameter_q);
      default:                 prdata = '0;
    endcase
  end

  // A write of the local value also reloads the running minimum in the core.
  assign cfg_o.in_count  = in_count_q;
  assign cfg_o.out_count = out_count_q;
  assign cfg_o.in_ids    = in_ids_q;
  assign cfg_o.out_ids   = out_ids_q;
  assign cfg_o.diameter  = diameter_q;
  assign cfg_o.init_wr   = wr_en && (reg_sel == pmpn_pkg::REG_INIT_MIN);
  assign cfg_o.init_val  = pwdata;

endmodule

[src/pmpn_unit.sv]
module pmpn_unit (
  input  logic [pmpn_pkg::CTR_W-1:0] count_i,
  input  logic                       match_i,
  input  logic [pmpn_pkg::CTR_W-1:0] phase_i,
  input  logic [pmpn_pkg::CTR_W-1:0] diameter_i,
  output logic [pmpn_pkg::CTR_W-1:0] count_o,
  output logic                       ge_phase_o,
  output logic                       ge_diam_o
);

  // One in-neighbour slot per use: saturating bump, then both threshold checks.
  assign count_o    = match_i ? pmpn_pkg::sat_inc(count_i) : count_i;
  assign ge_phase_o = (count_o >= phase_i);
  assign ge_diam_o  = (count_o >= diameter_i);

endmodule

[src/pmpn_obuf.sv]
module pmpn_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pmpn_pkg::res_t res_i,
  output logic           can_push_o,
  output logic           valid_o,
  input  logic           ready_i,
  output pmpn_pkg::res_t res_o
);

  logic           valid_q;
  pmpn_pkg::res_t res_q;

  assign can_push_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

[src/pmpn_core.sv]
`include "assert_macros.svh"

module pmpn_core #(
  parameter int unsigned MAX_NEIGHBORS = pmpn_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pmpn_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [pmpn_pkg::ID_W-1:0]         src_i,
  input  logic signed [pmpn_pkg::VAL_W-1:0] val_i,
  input  logic                              can_push_i,
  output logic                              push_o,
  output pmpn_pkg::res_t                    res_o
);

  localparam int unsigned SLOTS = (MAX_NEIGHBORS < pmpn_pkg::ID_SLOTS) ?
                                  MAX_NEIGHBORS : pmpn_pkg::ID_SLOTS;
  localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [pmpn_pkg::CNT_W-1:0] SLOTS_C = pmpn_pkg::CNT_W'(SLOTS);

  pmpn_pkg::state_e                  state_q, state_d;
  logic [pmpn_pkg::ID_W-1:0]         src_q, src_d;
  logic signed [pmpn_pkg::VAL_W-1:0] val_q, val_d;
  logic signed [pmpn_pkg::VAL_W-1:0] cur_min_q, cur_min_d;
  logic [pmpn_pkg::CNT_W-1:0]        idx_q, idx_d;
  logic                              rdy_q, rdy_d;
  logic                              diam_q, diam_d;
  logic                              send_done_q, send_done_d;
  logic                              finished_q, finished_d;
  logic [pmpn_pkg::CTR_W-1:0]        phase_q, phase_d;
  logic [pmpn_pkg::CTR_W-1:0]        counts_q [SLOTS];
  logic                              cnt_we;

  logic [pmpn_pkg::CNT_W-1:0]        nin, nout;
  logic [pmpn_pkg::CTR_W-1:0]        cnt_cur, cnt_new;
  logic                              match, ge_phase, ge_diam, is_last;

  assign nin  = (cfg_i.in_count  > SLOTS_C) ? SLOTS_C : cfg_i.in_count;
  assign nout = (cfg_i.out_count > SLOTS_C) ? SLOTS_C : cfg_i.out_count;

  assign cnt_cur = counts_q[idx_q[IW-1:0]];
  assign match   = (pmpn_pkg::id_at(cfg_i.in_ids, 2'(idx_q)) == src_q);
  assign is_last = (pmpn_pkg::CNT_W'(idx_q + 3'd1) == nout);

  pmpn_unit u_unit (
    .count_i    (cnt_cur),
    .match_i    (match),
    .phase_i    (phase_q),
    .diameter_i (cfg_i.diameter),
    .count_o    (cnt_new),
    .ge_phase_o (ge_phase),
    .ge_diam_o  (ge_diam)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmpn_pkg::ST_IDLE;
      cur_min_q   <= '0;
      idx_q       <= '0;
      rdy_q       <= 1'b0;
      diam_q      <= 1'b0;
      send_done_q <= 1'b0;
      finished_q  <= 1'b0;
      phase_q     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cur_min_q   <= cur_min_d;
      idx_q       <= idx_d;
      rdy_q       <= rdy_d;
      diam_q      <= diam_d;
      send_done_q <= send_done_d;
      finished_q  <= finished_d;
      phase_q     <= phase_d;
      if (cnt_we) begin
        counts_q[idx_q[IW-1:0]] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    val_d       = val_q;
    cur_min_d   = cur_min_q;
    idx_d       = idx_q;
    rdy_d       = rdy_q;
    diam_d      = diam_q;
    send_done_d = send_done_q;
    finished_d  = finished_q;
    phase_d     = phase_q;
    cnt_we      = 1'b0;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    res_o       = '0;

    if (cfg_i.init_wr) begin
      cur_min_d = cfg_i.init_val;
    end

    case (state_q)
      pmpn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          src_d = src_i;
          val_d = val_i;
          idx_d = '0;
          if (finished_q) begin
            state_d = pmpn_pkg::ST_DONE;
          end else if (pmpn_pkg::cmd_e'(cmd_i) == pmpn_pkg::CMD_START) begin
            send_done_d = 1'b0;
            phase_d     = pmpn_pkg::sat_inc(phase_q);
            state_d     = (nout == '0) ? pmpn_pkg::ST_IDLE : pmpn_pkg::ST_SEND;
          end else begin
            state_d = pmpn_pkg::ST_MIN;
          end
        end
      end
      pmpn_pkg::ST_MIN: begin
        if (val_q < cur_min_q) begin
          cur_min_d = val_q;
        end
        idx_d   = '0;
        rdy_d   = 1'b1;
        diam_d  = 1'b1;
        state_d = pmpn_pkg::ST_SCAN;
      end
      pmpn_pkg::ST_SCAN: begin
        if (idx_q < nin) begin
          cnt_we = 1'b1;
          rdy_d  = rdy_q & ge_phase;
          diam_d = diam_q & ge_diam;
          idx_d  = idx_q + 3'd1;
        end else begin
          idx_d   = '0;
          state_d = pmpn_pkg::ST_IDLE;
          if (rdy_q) begin
            phase_d     = pmpn_pkg::sat_inc(phase_q);
            finished_d  = diam_q;
            send_done_d = diam_q;
            if (nout != '0) begin
              state_d = pmpn_pkg::ST_SEND;
            end else if (diam_q) begin
              state_d = pmpn_pkg::ST_DONE;
            end
          end
        end
      end
      pmpn_pkg::ST_SEND: begin
        if (can_push_i) begin
          push_o           = 1'b1;
          res_o.send_valid = 1'b1;
          res_o.dest_id    = pmpn_pkg::id_at(cfg_i.out_ids, 2'(idx_q));
          res_o.min_value  = cur_min_q;
          res_o.last       = is_last;
          res_o.done_res   = send_done_q;
          idx_d            = idx_q + 3'd1;
          if (is_last) begin
            state_d = pmpn_pkg::ST_IDLE;
          end
        end
      end
      pmpn_pkg::ST_DONE: begin
        if (can_push_i) begin
          push_o          = 1'b1;
          res_o.min_value = cur_min_q;
          res_o.last      = 1'b1;
          res_o.done_res  = 1'b1;
          state_d         = pmpn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pmpn_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_NXT(a_fin_sticky, finished_q, finished_q, "finished flag was cleared")
  `ASSERT_IMP(a_push_room, push_o, can_push_i, "result pushed into a full output stage")
  `ASSERT_NXT(a_last_idle, push_o && res_o.last, state_q == pmpn_pkg::ST_IDLE, "no return to idle")
  `ASSERT_IMP(a_scan_range, state_q == pmpn_pkg::ST_SCAN, idx_q <= nin, "slot scan overran")

endmodule
